// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the quaternion to rotation matrix block.
// Depends on: a clock named clk and an active-low reset named rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define QRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrm assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define QRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrm assertion failed");

`endif

// ----- rtl/qrm_pkg.sv -----
// Shared constants for the quaternion to rotation matrix pipeline.
// No dependencies; imported by every module of the block.
package qrm_pkg;

    localparam int LANES  = 9;
    localparam int NPROD  = 10;
    localparam int NPAIR  = 6;
    localparam int THR_W  = 33;
    localparam logic [THR_W-1:0] THR_RESET = 33'd268;

    // product slots
    localparam int P_AA = 0;
    localparam int P_BB = 1;
    localparam int P_CC = 2;
    localparam int P_DD = 3;
    localparam int P_AB = 4;
    localparam int P_AC = 5;
    localparam int P_AD = 6;
    localparam int P_BC = 7;
    localparam int P_BD = 8;
    localparam int P_CD = 9;

    typedef logic [LANES-1:0] lane_mask_t;
    localparam lane_mask_t DIAG_LANES = 9'b100010001;

endpackage

// ----- rtl/quaternion_to_rotation_matrix.sv -----
// Quaternion to 3x3 rotation matrix, normalized by the squared norm, pipelined.
// Depends on qrm_pkg, qrm_products, qrm_sums, qrm_div_step, qrm_round, assert_macros.svh.
//
// Input stream s_axis: one quaternion per item, w, x, y, z signed fixed point.
// Output stream m_axis: nine matrix entries row by row in tdata, the small-norm
// flag in tuser; exactly one output item per input item, in order.
// Configuration: cfg_valid/cfg_data write the squared-norm threshold; cfg_ready
// is always high. Write it only while no item is in flight.
// The pipeline has one multiply stage, two sum stages, FRACTION_BITS + 1 restoring
// division steps and one rounding stage.
// Throughput is one item per cycle while the receiver accepts; the division steps are unrolled per bit.
// A stalled receiver holds the output register; bubbles inside the pipeline
// still fill, and s_axis_tready drops only once every stage holds an item.
// Reset clears all valid bits and loads the threshold with 268 (about 1e-6).
`include "assert_macros.svh"

module quaternion_to_rotation_matrix #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // mat_r0c0, mat_r0c1, mat_r0c2, mat_r1c0 .. mat_r2c2, zero fill
    output logic [((9*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0] m_axis_tuser,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [qrm_pkg::THR_W-1:0] cfg_data
);
    import qrm_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int MW   = 2 * SW + 1;
    localparam int NDIV = FB + 1;
    localparam int NS   = FB + 5;
    localparam int DIV0 = 3;
    localparam logic [SW-1:0] ONE_Q = SW'(1) << FB;

    logic [THR_W-1:0] thr_reg;
    logic [NS-1:0]    v_reg;
    logic [NS-1:0]    v_next;
    logic [NS-1:0]    en;

    logic signed [2*SW-1:0] prod [NPROD];
    logic [MW-1:0]          norm_s [NDIV+1];
    logic [MW-1:0]          rem_s  [NDIV+1][LANES];
    logic [FB:0]            quo_s  [NDIV+1][LANES];
    logic [LANES-1:0]       neg_s  [NDIV+1];
    logic                   deg_s  [NDIV+1];
    logic [SW-1:0]          mat    [LANES];
    logic                   deg_out;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // advance each stage when it is empty or its successor advances
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
        for (int k = 0; k < NS; k++)
        begin
            if (!en[k])
                v_next[k] = v_reg[k];
            else if (k == 0)
                v_next[k] = s_axis_tvalid;
            else
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = v_reg[NS-1];

    qrm_products #(.SW(SW)) u_products (
        .clk      (clk),
        .en       (en[0]),
        .w        (s_axis_tdata[0*SW +: SW]),
        .x        (s_axis_tdata[1*SW +: SW]),
        .y        (s_axis_tdata[2*SW +: SW]),
        .z        (s_axis_tdata[3*SW +: SW]),
        .prod_reg (prod)
    );

    qrm_sums #(.SW(SW)) u_sums (
        .clk      (clk),
        .en_a     (en[1]),
        .en_b     (en[2]),
        .prod     (prod),
        .thr      (thr_reg),
        .mag_reg  (rem_s[0]),
        .neg_reg  (neg_s[0]),
        .norm_reg (norm_s[0]),
        .deg_reg  (deg_s[0])
    );

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
            quo_s[0][k] = '0;
    end

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        qrm_div_step #(.SW(SW), .FB(FB), .DOUBLE(g != 0)) u_step (
            .clk      (clk),
            .en       (en[DIV0+g]),
            .norm     (norm_s[g]),
            .rem      (rem_s[g]),
            .quo      (quo_s[g]),
            .neg      (neg_s[g]),
            .deg      (deg_s[g]),
            .norm_reg (norm_s[g+1]),
            .rem_reg  (rem_s[g+1]),
            .quo_reg  (quo_s[g+1]),
            .neg_reg  (neg_s[g+1]),
            .deg_reg  (deg_s[g+1])
        );
    end

    qrm_round #(.SW(SW), .FB(FB)) u_round (
        .clk     (clk),
        .en      (en[NS-1]),
        .norm    (norm_s[NDIV]),
        .rem     (rem_s[NDIV]),
        .quo     (quo_s[NDIV]),
        .neg     (neg_s[NDIV]),
        .deg     (deg_s[NDIV]),
        .mat_reg (mat),
        .deg_reg (deg_out)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < LANES; k++)
            m_axis_tdata[k*SW +: SW] = mat[k];
    end

    assign m_axis_tuser = deg_out;

    `QRM_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `QRM_ASSERT_IMP(a_degenerate_identity, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[SW-1:0] == ONE_Q && m_axis_tdata[2*SW-1:SW] == '0)
    `QRM_ASSERT_IMP(a_diag_in_range, m_axis_tvalid,
        $signed(m_axis_tdata[5*SW-1:4*SW]) <= $signed(ONE_Q) && $signed(m_axis_tdata[5*SW-1:4*SW]) >= -$signed(ONE_Q))

endmodule

// ----- rtl/qrm_products.sv -----
// First pipeline stage: the ten pairwise products of the quaternion components.
// Depends on qrm_pkg.
module qrm_products #(
    parameter int SW = 16
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [SW-1:0] w,
    input  logic signed [SW-1:0] x,
    input  logic signed [SW-1:0] y,
    input  logic signed [SW-1:0] z,
    output logic signed [2*SW-1:0] prod_reg [qrm_pkg::NPROD]
);
    import qrm_pkg::*;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[P_AA] <= w * w;
            prod_reg[P_BB] <= x * x;
            prod_reg[P_CC] <= y * y;
            prod_reg[P_DD] <= z * z;
            prod_reg[P_AB] <= w * x;
            prod_reg[P_AC] <= w * y;
            prod_reg[P_AD] <= w * z;
            prod_reg[P_BC] <= x * y;
            prod_reg[P_BD] <= x * z;
            prod_reg[P_CD] <= y * z;
        end
    end

endmodule

// ----- rtl/qrm_sums.sv -----
// Two pipeline stages: pair sums, then the nine numerators as sign and magnitude,
// the squared norm and the small-norm flag. Depends on qrm_pkg.
module qrm_sums #(
    parameter int SW = 16
) (
    input  logic                   clk,
    input  logic                   en_a,
    input  logic                   en_b,
    input  logic signed [2*SW-1:0] prod [qrm_pkg::NPROD],
    input  logic [qrm_pkg::THR_W-1:0] thr,
    output logic [2*SW:0]          mag_reg [qrm_pkg::LANES],
    output logic [qrm_pkg::LANES-1:0] neg_reg,
    output logic [2*SW:0]          norm_reg,
    output logic                   deg_reg
);
    import qrm_pkg::*;

    localparam int NW = 2 * SW + 2;
    localparam int MW = 2 * SW + 1;
    localparam int CW = (MW > THR_W) ? MW : THR_W;

    logic signed [NW-1:0] sq_reg  [NPAIR];
    logic signed [NW-1:0] off_reg [NPAIR];
    logic signed [NW-1:0] num     [LANES];
    logic signed [NW-1:0] norm_sum;

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            sq_reg[0]  <= NW'(prod[P_AA]) + NW'(prod[P_BB]);
            sq_reg[1]  <= NW'(prod[P_CC]) + NW'(prod[P_DD]);
            sq_reg[2]  <= NW'(prod[P_AA]) + NW'(prod[P_CC]);
            sq_reg[3]  <= NW'(prod[P_BB]) + NW'(prod[P_DD]);
            sq_reg[4]  <= NW'(prod[P_AA]) + NW'(prod[P_DD]);
            sq_reg[5]  <= NW'(prod[P_BB]) + NW'(prod[P_CC]);
            off_reg[0] <= (NW'(prod[P_BC]) - NW'(prod[P_AD])) <<< 1;
            off_reg[1] <= (NW'(prod[P_AC]) + NW'(prod[P_BD])) <<< 1;
            off_reg[2] <= (NW'(prod[P_AD]) + NW'(prod[P_BC])) <<< 1;
            off_reg[3] <= (NW'(prod[P_CD]) - NW'(prod[P_AB])) <<< 1;
            off_reg[4] <= (NW'(prod[P_BD]) - NW'(prod[P_AC])) <<< 1;
            off_reg[5] <= (NW'(prod[P_AB]) + NW'(prod[P_CD])) <<< 1;
        end
    end

    always_comb
    begin
        num[0]   = sq_reg[0] - sq_reg[1];
        num[1]   = off_reg[0];
        num[2]   = off_reg[1];
        num[3]   = off_reg[2];
        num[4]   = sq_reg[2] - sq_reg[3];
        num[5]   = off_reg[3];
        num[6]   = off_reg[4];
        num[7]   = off_reg[5];
        num[8]   = sq_reg[4] - sq_reg[5];
        norm_sum = sq_reg[0] + sq_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                neg_reg[k] <= num[k][NW-1];
                mag_reg[k] <= num[k][NW-1] ? MW'(-num[k]) : MW'(num[k]);
            end
            norm_reg <= MW'(norm_sum);
            deg_reg  <= CW'(norm_sum[MW-1:0]) <= CW'(thr);
        end
    end

endmodule

// ----- rtl/qrm_div_step.sv -----
// One restoring division step for all nine lanes against the shared squared norm.
// Depends on qrm_pkg.
module qrm_div_step #(
    parameter int SW     = 16,
    parameter int FB     = 14,
    parameter bit DOUBLE = 1'b1
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [2*SW:0]             norm,
    input  logic [2*SW:0]             rem    [qrm_pkg::LANES],
    input  logic [FB:0]               quo    [qrm_pkg::LANES],
    input  logic [qrm_pkg::LANES-1:0] neg,
    input  logic                      deg,
    output logic [2*SW:0]             norm_reg,
    output logic [2*SW:0]             rem_reg [qrm_pkg::LANES],
    output logic [FB:0]               quo_reg [qrm_pkg::LANES],
    output logic [qrm_pkg::LANES-1:0] neg_reg,
    output logic                      deg_reg
);
    import qrm_pkg::*;

    localparam int MW = 2 * SW + 1;

    logic [MW:0]     trial [LANES];
    logic [MW:0]     diff  [LANES];
    logic [LANES-1:0] fits;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            trial[k] = DOUBLE ? {rem[k], 1'b0} : {1'b0, rem[k]};
            fits[k]  = trial[k] >= {1'b0, norm};
            diff[k]  = trial[k] - {1'b0, norm};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                rem_reg[k] <= fits[k] ? diff[k][MW-1:0] : trial[k][MW-1:0];
                quo_reg[k] <= {quo[k][FB-1:0], fits[k]};
            end
            norm_reg <= norm;
            neg_reg  <= neg;
            deg_reg  <= deg;
        end
    end

endmodule

// ----- rtl/qrm_round.sv -----
// Output stage: round to nearest, clamp to one, apply sign, substitute identity.
// Depends on qrm_pkg.
module qrm_round #(
    parameter int SW = 16,
    parameter int FB = 14
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [2*SW:0]             norm,
    input  logic [2*SW:0]             rem [qrm_pkg::LANES],
    input  logic [FB:0]               quo [qrm_pkg::LANES],
    input  logic [qrm_pkg::LANES-1:0] neg,
    input  logic                      deg,
    output logic [SW-1:0]             mat_reg [qrm_pkg::LANES],
    output logic                      deg_reg
);
    import qrm_pkg::*;

    localparam int QW = FB + 2;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FB;

    logic [QW-1:0] rounded [LANES];
    logic [QW-1:0] clamped [LANES];
    logic [SW-1:0] mag     [LANES];
    logic [SW-1:0] mat_next [LANES];

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rounded[k] = QW'(quo[k]) + QW'({rem[k], 1'b0} >= {1'b0, norm});
            clamped[k] = (rounded[k] > ONE_Q) ? ONE_Q : rounded[k];
            mag[k]     = SW'(clamped[k]);
            if (deg)
                mat_next[k] = DIAG_LANES[k] ? SW'(ONE_Q) : '0;
            else
                mat_next[k] = neg[k] ? -mag[k] : mag[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg <= mat_next;
            deg_reg <= deg;
        end
    end

endmodule
